@@ hw/rtl/t33h_pkg.sv @@
// Shared types and constants for the times-33 string bucket hash unit.
package t33h_pkg;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned BUCKET_W = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SHIFT    = 5;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // Register indexes (byte address is 4 * index)
    localparam logic REG_TABLE_SIZE   = 1'b0;
    localparam logic REG_BYTES_SIGNED = 1'b1;

    localparam logic [BUCKET_W-1:0] TABLE_SIZE_RST   = 16'd229;
    localparam logic                BYTES_SIGNED_RST = 1'b1;

    typedef struct packed {
        logic [BUCKET_W-1:0] table_size;
        logic                bytes_signed;
    } t33h_cfg_t;

    // One finished key waiting for its modulo
    typedef struct packed {
        logic [HASH_W-1:0]   raw_hash;
        logic [BUCKET_W-1:0] table_size;
    } t33h_job_t;

    typedef struct packed {
        logic      full;
        logic      empty;
        t33h_job_t head;
    } t33h_q_stat_t;

endpackage

@@ hw/rtl/t33h_ifs.sv @@
// Valid/ready channel interfaces for key bytes and bucket results.
interface t33h_key_if;
    logic                         valid;
    logic                         ready;
    logic [t33h_pkg::BYTE_W-1:0]  key_byte;
    logic                         last_byte;

    modport source (output valid, output key_byte, output last_byte, input ready);
    modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

interface t33h_bucket_if;
    logic                          valid;
    logic                          ready;
    logic [t33h_pkg::BUCKET_W-1:0] bucket;
    logic [t33h_pkg::HASH_W-1:0]   raw_hash;

    modport source (output valid, output bucket, output raw_hash, input ready);
    modport sink   (input valid, input bucket, input raw_hash, output ready);
endinterface

@@ hw/rtl/t33h_regs.sv @@
// APB configuration registers: table size and signed-byte mode.
module t33h_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [t33h_pkg::ADDR_W-1:0]    paddr,
    input  logic [t33h_pkg::DATA_W-1:0]    pwdata,
    output logic [t33h_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output t33h_pkg::t33h_cfg_t            cfg
);

    logic                            wr_en;
    logic                            reg_idx;
    logic [t33h_pkg::BUCKET_W-1:0]   table_size_reg;
    logic                            bytes_signed_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg   <= t33h_pkg::TABLE_SIZE_RST;
            bytes_signed_reg <= t33h_pkg::BYTES_SIGNED_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                t33h_pkg::REG_TABLE_SIZE:   table_size_reg   <= pwdata[t33h_pkg::BUCKET_W-1:0];
                t33h_pkg::REG_BYTES_SIGNED: bytes_signed_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            t33h_pkg::REG_TABLE_SIZE:
                prdata = {{(t33h_pkg::DATA_W-t33h_pkg::BUCKET_W){1'b0}}, table_size_reg};
            t33h_pkg::REG_BYTES_SIGNED:
                prdata = {{(t33h_pkg::DATA_W-1){1'b0}}, bytes_signed_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.table_size   = table_size_reg;
    assign cfg.bytes_signed = bytes_signed_reg;

endmodule

@@ hw/rtl/t33h_front.sv @@
// Front end: takes key bytes and runs the times-33 accumulator.
module t33h_front (
    input  logic                    clk,
    input  logic                    rst_n,
    t33h_key_if.sink                keys,
    input  t33h_pkg::t33h_cfg_t     cfg,
    input  logic                    q_full,
    output logic                    push,
    output t33h_pkg::t33h_job_t     job
);

    logic [t33h_pkg::HASH_W-1:0] acc_reg;
    logic [t33h_pkg::HASH_W-1:0] acc_next;
    logic [t33h_pkg::HASH_W-1:0] addend;
    logic [t33h_pkg::HASH_W-1:0] hashed;
    logic                        take;

    assign keys.ready = !q_full;
    assign take       = keys.valid && keys.ready;

    // Sign-extend high bytes in signed-char mode
    always_comb
    begin
        if (cfg.bytes_signed && keys.key_byte[t33h_pkg::BYTE_W-1])
            addend = {{(t33h_pkg::HASH_W-t33h_pkg::BYTE_W){1'b1}}, keys.key_byte};
        else
            addend = {{(t33h_pkg::HASH_W-t33h_pkg::BYTE_W){1'b0}}, keys.key_byte};
    end

    // A zero byte leaves the hash alone; the key still ends only on last_byte
    always_comb
    begin
        if (keys.key_byte != '0)
            hashed = (acc_reg << t33h_pkg::SHIFT) + acc_reg + addend;
        else
            hashed = acc_reg;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (take)
            acc_next = keys.last_byte ? '0 : hashed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign push           = take && keys.last_byte;
    assign job.raw_hash   = hashed;
    assign job.table_size = cfg.table_size;

endmodule

@@ hw/rtl/t33h_queue.sv @@
// Two-entry queue of finished keys between front and back ends.
module t33h_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  t33h_pkg::t33h_job_t     job,
    input  logic                    pop,
    output t33h_pkg::t33h_q_stat_t  stat
);

    t33h_pkg::t33h_job_t mem_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                do_push;
    logic                do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= job;
    end

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign stat.head  = mem_reg[rd_ptr_reg];

endmodule

@@ hw/rtl/t33h_back.sv @@
// Back end: bit-serial hash modulo table size and output register.
module t33h_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  t33h_pkg::t33h_q_stat_t  stat,
    output logic                    pop,
    t33h_bucket_if.source           buckets
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int unsigned CNT_W = $clog2(t33h_pkg::HASH_W);

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [t33h_pkg::HASH_W-1:0]   dvd_reg;
    logic [t33h_pkg::HASH_W-1:0]   hash_reg;
    logic [t33h_pkg::BUCKET_W-1:0] dsr_reg;
    logic [t33h_pkg::BUCKET_W-1:0] rem_reg;
    logic [t33h_pkg::BUCKET_W:0]   rem_shift;
    logic [t33h_pkg::BUCKET_W-1:0] rem_step;
    logic                          out_valid_reg;
    logic [t33h_pkg::BUCKET_W-1:0] bucket_reg;
    logic [t33h_pkg::HASH_W-1:0]   raw_hash_reg;
    logic                          out_free;
    logic                          load_out;

    assign pop      = (state_reg == ST_IDLE) && !stat.empty;
    assign out_free = !out_valid_reg || buckets.ready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[t33h_pkg::HASH_W-1]};
        if (rem_shift >= {1'b0, dsr_reg})
            rem_step = t33h_pkg::BUCKET_W'(rem_shift - {1'b0, dsr_reg});
        else
            rem_step = rem_shift[t33h_pkg::BUCKET_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!stat.empty) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CNT_W'(t33h_pkg::HASH_W - 1)) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (buckets.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dvd_reg  <= stat.head.raw_hash;
            hash_reg <= stat.head.raw_hash;
            dsr_reg  <= stat.head.table_size;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_step;
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (load_out)
        begin
            // Zero table size has no divisor: report bucket zero
            bucket_reg   <= (dsr_reg == '0) ? '0 : rem_reg;
            raw_hash_reg <= hash_reg;
        end
    end

    assign buckets.valid    = out_valid_reg;
    assign buckets.bucket   = bucket_reg;
    assign buckets.raw_hash = raw_hash_reg;

    a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_DIV)
        else $error("queued key did not start the modulo");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_DONE) |-> (rem_reg < dsr_reg || dsr_reg == '0))
        else $error("partial remainder not below table size");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(t33h_pkg::HASH_W - 1)) |=> state_reg == ST_DONE)
        else $error("modulo did not finish after all dividend bits");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || buckets.ready))
        else $error("result register overwritten while stalled");

endmodule

@@ hw/rtl/times33_string_bucket_hash_unit.sv @@
// Top level of the times-33 string bucket hash unit.
//
// keys carries one key byte per transaction, last_byte set on the final
// byte; an empty key is one zero byte with last_byte set. The front end
// takes one byte per cycle and folds it into a 32-bit accumulator
// (acc * 33 + byte). On the last byte the finished hash goes to a
// two-entry queue and the accumulator clears for the next key.
// The back end pops one key at a time and forms hash mod table_size with
// a restoring divider, one quotient bit per cycle. A key passes through
// the pop, 32 divider steps and the load of the output register; the back
// end pops no new key until the last result is in the output register.
// Bytes keep flowing at one per cycle while the queue has room; when
// buckets stalls, the result holds in its output register, the queue
// fills, and then keys drops ready until a slot frees.
// Registers over APB: table_size at 0x0 (reset 229), bytes_signed at
// 0x4 (reset 1). Write them only while the unit is idle.
// Reset clears the accumulator, queue, divider control and output valid.
module times33_string_bucket_hash_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [t33h_pkg::ADDR_W-1:0]    paddr,
    input  logic [t33h_pkg::DATA_W-1:0]    pwdata,
    output logic [t33h_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    t33h_key_if.sink                       keys,
    t33h_bucket_if.source                  buckets
);

    t33h_pkg::t33h_cfg_t    cfg;
    t33h_pkg::t33h_job_t    job;
    t33h_pkg::t33h_q_stat_t stat;
    logic                   push;
    logic                   pop;

    t33h_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    t33h_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys),
        .cfg    (cfg),
        .q_full (stat.full),
        .push   (push),
        .job    (job)
    );

    t33h_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .job   (job),
        .pop   (pop),
        .stat  (stat)
    );

    t33h_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .stat    (stat),
        .pop     (pop),
        .buckets (buckets)
    );

endmodule

@@ tb/times33_string_bucket_hash_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the times-33 string bucket hash unit.

typedef struct packed {
    logic [t33h_pkg::BUCKET_W-1:0] bucket;
    logic [t33h_pkg::HASH_W-1:0]   raw_hash;
} bucket_result_t;

class bucket_scoreboard;
    logic [t33h_pkg::HASH_W-1:0]   acc;
    logic [t33h_pkg::BUCKET_W-1:0] n_buckets;
    logic                          signed_bytes;
    bucket_result_t                expected_buckets[$];

    function new();
        acc          = '0;
        n_buckets    = t33h_pkg::TABLE_SIZE_RST;
        signed_bytes = t33h_pkg::BYTES_SIGNED_RST;
    endfunction

    function void set_config(logic [t33h_pkg::BUCKET_W-1:0] size, logic sgn);
        n_buckets    = size;
        signed_bytes = sgn;
    endfunction

    function int pending();
        return expected_buckets.size();
    endfunction

    // Fold one accepted key byte; on the last byte queue the expected bucket.
    function void note_key_byte(logic [t33h_pkg::BYTE_W-1:0] b, logic last);
        logic [t33h_pkg::HASH_W-1:0] addend;
        logic [t33h_pkg::HASH_W-1:0] h;
        bucket_result_t              r;
        h = acc;
        // a zero byte leaves the hash alone; the key still ends only on last
        if (b != 0)
        begin
            addend = (signed_bytes && b[7]) ? {24'hFF_FFFF, b} : {24'h0, b};
            h = (h << t33h_pkg::SHIFT) + h + addend;
        end
        if (!last)
        begin
            acc = h;
        end
        else
        begin
            r.raw_hash = h;
            r.bucket   = (n_buckets == 0) ? '0 : t33h_pkg::BUCKET_W'(h % n_buckets);
            expected_buckets.push_back(r);
            acc = '0;
        end
    endfunction

    // Returns an empty string on a match, else a description of the fault.
    function string check_bucket(logic [t33h_pkg::BUCKET_W-1:0] bucket,
                                 logic [t33h_pkg::HASH_W-1:0] raw_hash);
        bucket_result_t r;
        string          msg;
        if (expected_buckets.size() == 0)
            return $sformatf("unexpected result bucket=%0d raw_hash=%08h", bucket, raw_hash);
        r   = expected_buckets.pop_front();
        msg = "";
        if (bucket !== r.bucket)
            msg = {msg, $sformatf(" bucket got %0d exp %0d", bucket, r.bucket)};
        if (raw_hash !== r.raw_hash)
            msg = {msg, $sformatf(" raw_hash got %08h exp %08h", raw_hash, r.raw_hash)};
        return msg;
    endfunction
endclass

module times33_string_bucket_hash_unit_test;

    localparam logic [t33h_pkg::ADDR_W-1:0] ADDR_TABLE_SIZE   =
        {t33h_pkg::REG_TABLE_SIZE, 2'b00};
    localparam logic [t33h_pkg::ADDR_W-1:0] ADDR_BYTES_SIGNED =
        {t33h_pkg::REG_BYTES_SIGNED, 2'b00};
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_CYCLES  = 400;
    localparam int ITEMS_PER_SEG = 140;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [t33h_pkg::ADDR_W-1:0] paddr;
    logic [t33h_pkg::DATA_W-1:0] pwdata;
    logic [t33h_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    t33h_key_if    keys_if();
    t33h_bucket_if buckets_if();

    bucket_scoreboard sb = new();

    int errors        = 0;
    int items_sent    = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit stall_request = 1'b0;
    int hold_left     = 0;

    times33_string_bucket_hash_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keys    (keys_if),
        .buckets (buckets_if)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t:%s", $realtime, msg);
        errors++;
    endtask

    task automatic write_reg(input logic [t33h_pkg::ADDR_W-1:0] addr,
                             input logic [t33h_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Let all pending keys come out and the divider settle, then reprogram.
    task automatic configure(input logic [t33h_pkg::BUCKET_W-1:0] size, input logic sgn);
        keys_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(ADDR_TABLE_SIZE, t33h_pkg::DATA_W'(size));
        write_reg(ADDR_BYTES_SIGNED, t33h_pkg::DATA_W'(sgn));
        sb.set_config(size, sgn);
    endtask

    task automatic send_byte(input logic [t33h_pkg::BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            keys_if.valid <= 1'b0;
            @(posedge clk);
        end
        keys_if.valid     <= 1'b1;
        keys_if.key_byte  <= b;
        keys_if.last_byte <= last;
        @(posedge clk);
        while (!keys_if.ready)
            @(posedge clk);
        sb.note_key_byte(b, last);
        items_sent++;
    endtask

    task automatic send_random_key();
        int                          len;
        logic [t33h_pkg::BYTE_W-1:0] b;
        if ($urandom_range(19) == 0)
        begin
            send_byte(8'h00, 1'b1);
            return;
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
        begin
            b = ($urandom_range(24) == 0) ? 8'h00 : t33h_pkg::BYTE_W'($urandom_range(255, 1));
            send_byte(b, i == len - 1);
        end
    endtask

    // Result side: random back-pressure plus an occasional long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buckets_if.ready <= 1'b0;
        end
        else
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left     = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                buckets_if.ready <= 1'b0;
            end
            else
            begin
                buckets_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && buckets_if.valid && buckets_if.ready)
        begin
            msg = sb.check_bucket(buckets_if.bucket, buckets_if.raw_hash);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    initial
    begin
        #5ms;
        $display("times33_string_bucket_hash_unit: mismatch");
        $finish;
    end

    initial
    begin
        logic [t33h_pkg::BUCKET_W-1:0] seg_size[6];
        logic                          seg_signed[6];
        int                            seg_end;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        keys_if.valid     = 1'b0;
        keys_if.key_byte  = '0;
        keys_if.last_byte = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 7;
        rx_idle_pct = 54;

        // Directed keys under the reset settings.
        send_byte(8'h00, 1'b1);              // empty key
        send_byte(8'hFF, 1'b1);              // top byte as signed char
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h41, 1'b0);              // zero byte inside a key
        send_byte(8'h00, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h00, 1'b0);              // leading zero byte
        send_byte(8'h55, 1'b1);
        for (int i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);        // long run to wrap the hash

        // No divisor: bucket reads zero.
        configure(16'd0, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'hC8, 1'b1);

        seg_size   = '{16'd1, 16'hFFFF, t33h_pkg::BUCKET_W'($urandom_range(65534, 2)),
                       16'd229, t33h_pkg::BUCKET_W'($urandom_range(65534, 2)), 16'hFFFF};
        seg_signed = '{1'b0, 1'b1, 1'($urandom_range(1)), 1'b0, 1'b1, 1'b0};

        for (int seg = 0; seg < 6; seg++)
        begin
            configure(seg_size[seg], seg_signed[seg]);
            case (seg / 2)
                0:
                begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 54;
                end
                1:
                begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 7;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // hold the result side while keys keep coming
            if (seg == 4)
                stall_request = 1'b1;
            seg_end = items_sent + ITEMS_PER_SEG;
            while (items_sent < seg_end)
                send_random_key();
        end

        keys_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("times33_string_bucket_hash_unit: match");
        else
            $display("times33_string_bucket_hash_unit: mismatch");
        $finish;
    end
endmodule
